// ===== rtl/rgb24_palette_nearest_match_macros.svh =====
// Assertion helpers shared by the checker.
`ifndef RGB24_PALETTE_NEAREST_MATCH_MACROS_SVH
`define RGB24_PALETTE_NEAREST_MATCH_MACROS_SVH

// Same-cycle implication, off while in reset.
`define RPNM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpnm: implication check failed");

// Next-cycle implication, off while in reset.
`define RPNM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpnm: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define RPNM_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rpnm: reset check failed");

`endif

// ===== rtl/rpnm_pkg.sv =====
package rpnm_pkg;

  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int MAX_ROW_WIDTH_DEF = 4096;

  localparam int COLOUR_W  = 24;
  localparam int WORD_W    = 32;
  localparam int IDX_W     = 8;
  localparam int RW_W      = 13;
  localparam int PC_W      = 9;
  localparam int CFG_IDX_W = 2;

  // Error sum of three byte differences stays below 1024; start above any of them.
  localparam int ERR_W = 14;
  localparam logic [ERR_W-1:0] ERR_START = 14'd8192;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_COUNT = 2'd1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DATA = 1'b1;

  typedef struct packed {
    logic                start;
    logic [COLOUR_W-1:0] pixel;
  } srch_req_t;

  typedef struct packed {
    logic done;
    logic empty;
  } srch_rsp_t;

endpackage

// ===== rtl/rpnm_ram.sv =====
module rpnm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/rpnm_sad.sv =====
module rpnm_sad (
  input  logic [rpnm_pkg::COLOUR_W-1:0] pixel,
  input  logic [rpnm_pkg::COLOUR_W-1:0] colour,
  output logic [rpnm_pkg::ERR_W-1:0]    err
);

  logic [7:0] d_hi, d_mid, d_lo;
  logic [9:0] sum;

  // Pixel channel order is reversed against the palette: high byte meets low byte.
  always_comb begin
    d_hi  = (pixel[23:16] > colour[7:0])   ? pixel[23:16] - colour[7:0]
                                           : colour[7:0] - pixel[23:16];
    d_mid = (pixel[15:8] > colour[15:8])   ? pixel[15:8] - colour[15:8]
                                           : colour[15:8] - pixel[15:8];
    d_lo  = (pixel[7:0] > colour[23:16])   ? pixel[7:0] - colour[23:16]
                                           : colour[23:16] - pixel[7:0];
    sum   = 10'(d_hi) + 10'(d_mid) + 10'(d_lo);
  end

  assign err = rpnm_pkg::ERR_W'(sum);

endmodule

// ===== rtl/rpnm_search.sv =====
module rpnm_search #(
  parameter int PALETTE_DEPTH = rpnm_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rpnm_pkg::srch_req_t                 req,
  input  logic [$clog2(PALETTE_DEPTH+1)-1:0]  count,
  output rpnm_pkg::srch_rsp_t                 rsp,
  output logic [$clog2(PALETTE_DEPTH)-1:0]    best_index,
  output logic [$clog2(PALETTE_DEPTH)-1:0]    ram_raddr,
  input  logic [rpnm_pkg::COLOUR_W-1:0]       ram_rdata
);

  localparam int AW   = $clog2(PALETTE_DEPTH);
  localparam int CNTW = $clog2(PALETTE_DEPTH+1);

  logic                          busy_r, busy_nxt;
  logic                          chk_vld_r, chk_vld_nxt;
  logic [CNTW-1:0]               rd_idx_r, rd_idx_nxt;
  logic [CNTW-1:0]               cnt_r, cnt_nxt;
  logic [AW-1:0]                 chk_idx_r, chk_idx_nxt;
  logic [AW-1:0]                 best_idx_r, best_idx_nxt;
  logic [rpnm_pkg::ERR_W-1:0]    best_err_r, best_err_nxt;
  logic [rpnm_pkg::COLOUR_W-1:0] pix_r, pix_nxt;
  logic                          empty_r, empty_nxt;
  logic [rpnm_pkg::ERR_W-1:0]    err;
  logic                          issue;
  logic                          done;

  rpnm_sad u_sad (
    .pixel  (pix_r),
    .colour (ram_rdata),
    .err    (err)
  );

  assign issue     = busy_r && (rd_idx_r < cnt_r);
  assign done      = busy_r && !issue && !chk_vld_r;
  assign ram_raddr = rd_idx_r[AW-1:0];

  always_comb begin
    busy_nxt     = busy_r;
    chk_vld_nxt  = issue;
    chk_idx_nxt  = rd_idx_r[AW-1:0];
    rd_idx_nxt   = rd_idx_r;
    cnt_nxt      = cnt_r;
    best_idx_nxt = best_idx_r;
    best_err_nxt = best_err_r;
    pix_nxt      = pix_r;
    empty_nxt    = empty_r;
    if (issue) begin
      rd_idx_nxt = rd_idx_r + CNTW'(1);
    end
    // Strict compare keeps the lowest index on a tie.
    if (chk_vld_r && (err < best_err_r)) begin
      best_err_nxt = err;
      best_idx_nxt = chk_idx_r;
    end
    if (done) begin
      busy_nxt = 1'b0;
    end
    if (req.start) begin
      busy_nxt     = 1'b1;
      chk_vld_nxt  = 1'b0;
      rd_idx_nxt   = '0;
      cnt_nxt      = count;
      best_idx_nxt = '0;
      best_err_nxt = rpnm_pkg::ERR_START;
      pix_nxt      = req.pixel;
      empty_nxt    = (count == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      chk_vld_r <= 1'b0;
      rd_idx_r  <= '0;
    end else begin
      busy_r    <= busy_nxt;
      chk_vld_r <= chk_vld_nxt;
      rd_idx_r  <= rd_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    chk_idx_r  <= chk_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_err_r <= best_err_nxt;
    pix_r      <= pix_nxt;
    empty_r    <= empty_nxt;
  end

  assign rsp.done   = done;
  assign rsp.empty  = empty_r;
  assign best_index = best_idx_r;

endmodule

// ===== rtl/rgb24_palette_nearest_match.sv =====
// Nearest palette colour match for packed 24-bit RGB rows.
//
// Input channel (in_valid/in_ready): op 0 writes in_entry_colour into palette
// slot in_entry_index; op 1 delivers one 32-bit data word of packed pixels
// (three words carry four pixels, each row starts on a new word).
// Result channel (out_valid/out_ready): one word per pixel with the index of
// the nearest palette entry by sum of absolute channel differences, the
// empty-palette flag, row_end on the last pixel of a row and last on the
// final pixel of the data word (a word yields one or two pixels).
// Config channel (cfg_valid/cfg_ready, always ready): index 0 row_width,
// index 1 palette_count; write only while the block is idle.
// Search: the search reads one palette entry per cycle from the palette RAM
// through a single SAD compare unit, P = min(palette_count, PALETTE_DEPTH)
// entries per pixel and none for an empty palette. in_ready is low from the
// taken data word until its last pixel is loaded into the output register,
// so the block takes no new word or palette write before then.
// When the receiver stalls, a finished pixel waits in the search unit until
// the output register frees up. Reset clears the row position, pal_count and
// out_valid, sets row_width to 1; palette contents are undefined until written.
module rgb24_palette_nearest_match #(
  parameter int PALETTE_DEPTH = rpnm_pkg::PALETTE_DEPTH_DEF,
  parameter int MAX_ROW_WIDTH = rpnm_pkg::MAX_ROW_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_op,
  input  logic [rpnm_pkg::IDX_W-1:0]     in_entry_index,
  input  logic [rpnm_pkg::COLOUR_W-1:0]  in_entry_colour,
  input  logic [rpnm_pkg::WORD_W-1:0]    in_data_word,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rpnm_pkg::IDX_W-1:0]     out_colour_index,
  output logic                           out_no_palette,
  output logic                           out_row_end,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rpnm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rpnm_pkg::RW_W-1:0]      cfg_wdata
);

  localparam int AW   = $clog2(PALETTE_DEPTH);
  localparam int CNTW = $clog2(PALETTE_DEPTH+1);
  localparam int WW   = $clog2(MAX_ROW_WIDTH+1);
  localparam int EW   = (WW > rpnm_pkg::RW_W) ? WW : rpnm_pkg::RW_W;
  localparam int COLW = $clog2(MAX_ROW_WIDTH);
  localparam logic [EW-1:0] MAX_W = EW'(MAX_ROW_WIDTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SRCH = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t                        state_r, state_nxt;
  logic [rpnm_pkg::RW_W-1:0]     row_width_r, row_width_nxt;
  logic [rpnm_pkg::PC_W-1:0]     pal_count_r, pal_count_nxt;
  logic [1:0]                    word_phase_r, word_phase_nxt;
  logic [rpnm_pkg::WORD_W-1:0]   held_word_r, held_word_nxt;
  logic [COLW-1:0]               col_r, col_nxt;
  logic [rpnm_pkg::COLOUR_W-1:0] pix1_r, pix1_nxt;
  logic                          two_r, two_nxt;
  logic                          second_r, second_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [rpnm_pkg::IDX_W-1:0]    out_idx_r, out_idx_nxt;
  logic                          out_np_r, out_np_nxt;
  logic                          out_end_r, out_end_nxt;
  logic                          out_last_r, out_last_nxt;

  logic                          in_acc;
  logic                          pal_we;
  logic [rpnm_pkg::COLOUR_W-1:0] pix0;
  logic [EW-1:0]                 rw_ext;
  logic [EW-1:0]                 width_eff;
  logic [EW-1:0]                 col_inc;
  logic                          row_end;
  logic [CNTW-1:0]               cnt_eff;
  logic                          out_free;
  logic                          load;

  rpnm_pkg::srch_req_t           req;
  rpnm_pkg::srch_rsp_t           rsp;
  logic [AW-1:0]                 best_index;
  logic [AW-1:0]                 ram_raddr;
  logic [rpnm_pkg::COLOUR_W-1:0] ram_rdata;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign pal_we    = in_acc && (in_op == rpnm_pkg::OP_LOAD) &&
                     ({1'b0, in_entry_index} < 9'(PALETTE_DEPTH));

  rpnm_ram #(
    .WIDTH (rpnm_pkg::COLOUR_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (in_entry_index[AW-1:0]),
    .wdata (in_entry_colour),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rpnm_search #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_search (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .count      (cnt_eff),
    .rsp        (rsp),
    .best_index (best_index),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  // First pixel of the word, joined with the held word by phase.
  always_comb begin
    case (word_phase_r)
      2'd1:    pix0 = {in_data_word[15:0], held_word_r[31:24]};
      2'd2:    pix0 = {in_data_word[7:0], held_word_r[31:16]};
      default: pix0 = in_data_word[23:0];
    endcase
  end

  always_comb begin
    rw_ext    = EW'(row_width_r);
    width_eff = ((row_width_r == '0) || (rw_ext > MAX_W)) ? MAX_W : rw_ext;
    col_inc   = EW'(col_r) + EW'(1);
    row_end   = (col_inc >= width_eff);
    cnt_eff   = (pal_count_r > 9'(PALETTE_DEPTH)) ? CNTW'(PALETTE_DEPTH)
                                                  : CNTW'(pal_count_r);
    out_free  = !out_valid_r || out_ready;
  end

  always_comb begin
    row_width_nxt = row_width_r;
    pal_count_nxt = pal_count_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rpnm_pkg::REG_ROW_WIDTH:     row_width_nxt = cfg_wdata;
        rpnm_pkg::REG_PALETTE_COUNT: pal_count_nxt = cfg_wdata[rpnm_pkg::PC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    word_phase_nxt = word_phase_r;
    held_word_nxt  = held_word_r;
    col_nxt        = col_r;
    pix1_nxt       = pix1_r;
    two_nxt        = two_r;
    second_nxt     = second_r;
    out_idx_nxt    = out_idx_r;
    out_np_nxt     = out_np_r;
    out_end_nxt    = out_end_r;
    out_last_nxt   = out_last_r;
    req.start      = 1'b0;
    req.pixel      = (state_r == S_IDLE) ? pix0 : pix1_r;
    load           = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_op == rpnm_pkg::OP_DATA)) begin
          req.start     = 1'b1;
          held_word_nxt = in_data_word;
          pix1_nxt      = in_data_word[31:8];
          two_nxt       = (word_phase_r == 2'd2);
          second_nxt    = 1'b0;
          state_nxt     = S_SRCH;
        end
      end
      S_SRCH: begin
        if (rsp.done) begin
          if (out_free) begin
            load = 1'b1;
          end else begin
            state_nxt = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          load = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (load) begin
      out_idx_nxt = rpnm_pkg::IDX_W'(best_index);
      out_np_nxt  = rsp.empty;
      out_end_nxt = row_end;
      col_nxt     = row_end ? '0 : col_inc[COLW-1:0];
      // Second pixel of a phase-2 word, unless the row ended on the first.
      if (two_r && !second_r && !row_end) begin
        req.start    = 1'b1;
        second_nxt   = 1'b1;
        out_last_nxt = 1'b0;
        state_nxt    = S_SRCH;
      end else begin
        out_last_nxt   = 1'b1;
        state_nxt      = S_IDLE;
        word_phase_nxt = (row_end || two_r) ? 2'd0 : word_phase_r + 2'd1;
      end
    end
  end

  assign out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      row_width_r  <= rpnm_pkg::RW_W'(1);
      pal_count_r  <= '0;
      word_phase_r <= '0;
      held_word_r  <= '0;
      col_r        <= '0;
      two_r        <= 1'b0;
      second_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      row_width_r  <= row_width_nxt;
      pal_count_r  <= pal_count_nxt;
      word_phase_r <= word_phase_nxt;
      held_word_r  <= held_word_nxt;
      col_r        <= col_nxt;
      two_r        <= two_nxt;
      second_r     <= second_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix1_r     <= pix1_nxt;
    out_idx_r  <= out_idx_nxt;
    out_np_r   <= out_np_nxt;
    out_end_r  <= out_end_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_colour_index = out_idx_r;
  assign out_no_palette   = out_np_r;
  assign out_row_end      = out_end_r;
  assign out_last         = out_last_r;

endmodule

// ===== rtl/rpnm_checker.sv =====
`include "rgb24_palette_nearest_match_macros.svh"

module rpnm_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           in_op,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [rpnm_pkg::IDX_W-1:0]     out_colour_index,
  input logic                           out_no_palette,
  input logic                           out_last
);

  // Hold a stalled result word.
  `RPNM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // A data word keeps the block busy.
  `RPNM_ASSERT_NXT(a_busy_after_data, clk, rst_n,
    in_valid && in_ready && (in_op == rpnm_pkg::OP_DATA), !in_ready)

  // While a word still owes pixels, take no new word.
  `RPNM_ASSERT_IMP(a_no_accept_mid_word, clk, rst_n, out_valid && !out_last, !in_ready)

  // An empty palette reports slot zero.
  `RPNM_ASSERT_IMP(a_empty_index, clk, rst_n,
    out_valid && out_no_palette, out_colour_index == '0)

  // Drop any result during reset.
  `RPNM_ASSERT_NXT_ALWAYS(a_reset_clears, clk, !rst_n, !out_valid)

endmodule

bind rgb24_palette_nearest_match rpnm_checker u_rpnm_checker (.*);

// ===== sim/rgb24_palette_nearest_match_tb.sv =====
module rgb24_palette_nearest_match_tb;

  localparam int DEPTH = rpnm_pkg::PALETTE_DEPTH_DEF;
  localparam int MAXW = rpnm_pkg::MAX_ROW_WIDTH_DEF;
  localparam int IDX_W = rpnm_pkg::IDX_W;
  localparam int COLOUR_W = rpnm_pkg::COLOUR_W;
  localparam int WORD_W = rpnm_pkg::WORD_W;
  localparam int CFG_IDX_W = rpnm_pkg::CFG_IDX_W;
  localparam int RW_W = rpnm_pkg::RW_W;
  localparam int PC_W = rpnm_pkg::PC_W;
  localparam longint TIMEOUT = 64'd48_000_000;

  typedef enum logic [1:0] {GRP_WORD0, GRP_WORD1, GRP_WORD2} group_pos_t;

  typedef struct {
    logic [IDX_W-1:0] colour_index;
    logic             no_palette;
    logic             row_end;
    logic             last;
  } pixel_match_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_op = rpnm_pkg::OP_LOAD;
  logic [IDX_W-1:0]     in_entry_index = '0;
  logic [COLOUR_W-1:0]  in_entry_colour = '0;
  logic [WORD_W-1:0]    in_data_word = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [IDX_W-1:0]     out_colour_index;
  logic                 out_no_palette;
  logic                 out_row_end;
  logic                 out_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = rpnm_pkg::REG_ROW_WIDTH;
  logic [RW_W-1:0]      cfg_wdata = '0;

  // predictor state
  logic [COLOUR_W-1:0] palette_copy [DEPTH];
  group_pos_t          group_pos = GRP_WORD0;
  logic [WORD_W-1:0]   held_word = '0;
  int                  column_pos = 0;
  logic [RW_W-1:0]     row_width_reg = 13'd1;
  logic [PC_W-1:0]     pal_count_reg = '0;

  pixel_match_t expected_matches [$];
  int           mismatch_count = 0;
  bit           idle_en = 1'b1;

  always #6 clk = ~clk;

  rgb24_palette_nearest_match uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_entry_index   (in_entry_index),
    .in_entry_colour  (in_entry_colour),
    .in_data_word     (in_data_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_colour_index (out_colour_index),
    .out_no_palette   (out_no_palette),
    .out_row_end      (out_row_end),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic int byte_dist(logic [7:0] a, logic [7:0] b);
    return (a > b) ? int'(a - b) : int'(b - a);
  endfunction

  function automatic logic [IDX_W-1:0] nearest_entry(logic [COLOUR_W-1:0] px, int n);
    int best_err;
    int best;
    int err;
    best_err = int'(rpnm_pkg::ERR_START);
    best = 0;
    for (int i = 0; i < n; i++) begin
      // pixel channels run in the opposite byte order to the palette
      err = byte_dist(px[23:16], palette_copy[i][7:0])
          + byte_dist(px[15:8], palette_copy[i][15:8])
          + byte_dist(px[7:0], palette_copy[i][23:16]);
      if (err < best_err) begin
        best_err = err;
        best = i;
      end
    end
    return best[IDX_W-1:0];
  endfunction

  function automatic pixel_match_t match_pixel(logic [COLOUR_W-1:0] px);
    pixel_match_t m;
    int n;
    int w;
    n = (pal_count_reg > DEPTH) ? DEPTH : int'(pal_count_reg);
    w = (row_width_reg == 0 || row_width_reg > MAXW) ? MAXW : int'(row_width_reg);
    m.colour_index = nearest_entry(px, n);
    m.no_palette = (n == 0);
    column_pos++;
    m.row_end = (column_pos >= w);
    if (m.row_end) column_pos = 0;
    m.last = 1'b0;
    return m;
  endfunction

  function automatic void predict_data_word(logic [WORD_W-1:0] w);
    pixel_match_t first;
    pixel_match_t second;
    bit two;
    two = 1'b0;
    case (group_pos)
      GRP_WORD0: begin
        first = match_pixel(w[23:0]);
        group_pos = first.row_end ? GRP_WORD0 : GRP_WORD1;
      end
      GRP_WORD1: begin
        first = match_pixel({w[15:0], held_word[31:24]});
        group_pos = first.row_end ? GRP_WORD0 : GRP_WORD2;
      end
      default: begin
        first = match_pixel({w[7:0], held_word[31:16]});
        // a row ending on the first pixel leaves the rest of the word as padding
        if (!first.row_end) begin
          second = match_pixel(w[31:8]);
          two = 1'b1;
        end
        group_pos = GRP_WORD0;
      end
    endcase
    held_word = w;
    if (two) begin
      second.last = 1'b1;
      expected_matches.push_back(first);
      expected_matches.push_back(second);
    end else begin
      first.last = 1'b1;
      expected_matches.push_back(first);
    end
  endfunction

  always @(posedge clk) begin : check_and_predict
    pixel_match_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_matches.size() == 0) begin
          report_mismatch($sformatf("unexpected result, colour_index %0d", out_colour_index));
        end else begin
          want = expected_matches.pop_front();
          if (out_colour_index !== want.colour_index)
            report_mismatch($sformatf("colour_index %0d, want %0d",
                                      out_colour_index, want.colour_index));
          if (out_no_palette !== want.no_palette)
            report_mismatch($sformatf("no_palette %b, want %b", out_no_palette, want.no_palette));
          if (out_row_end !== want.row_end)
            report_mismatch($sformatf("row_end %b, want %b", out_row_end, want.row_end));
          if (out_last !== want.last)
            report_mismatch($sformatf("last %b, want %b", out_last, want.last));
        end
      end
      if (in_valid && in_ready) begin
        if (in_op == rpnm_pkg::OP_LOAD) palette_copy[in_entry_index] = in_entry_colour;
        else predict_data_word(in_data_word);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rpnm_pkg::REG_ROW_WIDTH:     row_width_reg = cfg_wdata;
          rpnm_pkg::REG_PALETTE_COUNT: pal_count_reg = cfg_wdata[PC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // result side back-pressure
  initial begin
    forever begin
      @(negedge clk);
      if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic send_item(input logic op, input logic [IDX_W-1:0] slot,
                           input logic [COLOUR_W-1:0] colour, input logic [WORD_W-1:0] w);
    int gap;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_entry_index <= slot;
    in_entry_colour <= colour;
    in_data_word <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_word(input logic [WORD_W-1:0] w);
    send_item(rpnm_pkg::OP_DATA, IDX_W'($urandom()), COLOUR_W'($urandom()), w);
  endtask

  task automatic send_entry(input logic [IDX_W-1:0] slot, input logic [COLOUR_W-1:0] colour);
    send_item(rpnm_pkg::OP_LOAD, slot, colour, $urandom());
  endtask

  // drop valid, then hold until every expected word has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RW_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_empty_palette_after_reset();
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word($urandom());
    drain_results();
  endtask

  task automatic load_full_palette();
    for (int i = 0; i < DEPTH; i++) begin
      case (i)
        0, 2:    send_entry(IDX_W'(i), 24'h000000);
        1:       send_entry(IDX_W'(i), 24'hFFFFFF);
        3:       send_entry(IDX_W'(i), 24'h0000FF);
        default: send_entry(IDX_W'(i), COLOUR_W'($urandom()));
      endcase
    end
    drain_results();
  endtask

  task automatic test_channel_order_and_ties();
    write_reg(rpnm_pkg::REG_ROW_WIDTH, 13'd1);
    write_reg(rpnm_pkg::REG_PALETTE_COUNT, 13'd4);
    send_word(32'h00FF_0000);
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_00FF);
    drain_results();
  endtask

  task automatic test_row_tails();
    write_reg(rpnm_pkg::REG_ROW_WIDTH, 13'd3);
    repeat (4) send_word($urandom());
    drain_results();
    write_reg(rpnm_pkg::REG_ROW_WIDTH, 13'd4);
    repeat (3) send_word($urandom());
    drain_results();
    write_reg(rpnm_pkg::REG_ROW_WIDTH, 13'd2);
    send_entry(8'd200, COLOUR_W'($urandom()));
    repeat (2) send_word($urandom());
    drain_results();
  endtask

  task automatic test_palette_count_limits();
    write_reg(rpnm_pkg::REG_ROW_WIDTH, 13'd5);
    write_reg(rpnm_pkg::REG_PALETTE_COUNT, 13'h1E00);
    send_word($urandom());
    drain_results();
    write_reg(rpnm_pkg::REG_PALETTE_COUNT, 13'h1FFF);
    send_word($urandom());
    drain_results();
    write_reg(rpnm_pkg::REG_PALETTE_COUNT, 13'd256);
    send_word(32'hFFFF_FFFF);
    drain_results();
    write_reg(rpnm_pkg::REG_PALETTE_COUNT, 13'd1);
    send_word($urandom());
    drain_results();
  endtask

  task automatic test_row_width_limits();
    write_reg(rpnm_pkg::REG_PALETTE_COUNT, 13'd6);
    write_reg(rpnm_pkg::REG_ROW_WIDTH, 13'd0);
    repeat (3) send_word($urandom());
    drain_results();
    // narrower than the current column: the next pixel closes the row
    write_reg(rpnm_pkg::REG_ROW_WIDTH, 13'd2);
    send_word($urandom());
    drain_results();
    write_reg(rpnm_pkg::REG_ROW_WIDTH, 13'h1FFF);
    send_word($urandom());
    drain_results();
    write_reg(rpnm_pkg::REG_ROW_WIDTH, 13'd4096);
    send_word($urandom());
    drain_results();
    write_reg(rpnm_pkg::REG_ROW_WIDTH, 13'd4097);
    send_word($urandom());
    drain_results();
  endtask

  task automatic test_random_traffic(input int phases, input int per_phase);
    logic [RW_W-1:0] width;
    logic [RW_W-1:0] count;
    for (int p = 0; p < phases; p++) begin
      drain_results();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: width = RW_W'($urandom_range(1, 5));
        4, 5, 6, 7: width = RW_W'($urandom_range(6, 40));
        8:          width = RW_W'($urandom_range(41, 300));
        default: begin
          case ($urandom_range(0, 3))
            0:       width = 13'd0;
            1:       width = 13'd4096;
            2:       width = 13'h1FFF;
            default: width = RW_W'($urandom_range(4097, 8191));
          endcase
        end
      endcase
      case ($urandom_range(0, 19))
        0:       count = RW_W'($urandom_range(0, 8191));
        1:       count = RW_W'($urandom_range(257, 511));
        2, 3:    count = RW_W'($urandom_range(65, 256));
        4, 5, 6, 7, 8: count = RW_W'($urandom_range(9, 64));
        default: count = RW_W'($urandom_range(0, 8));
      endcase
      write_reg(rpnm_pkg::REG_ROW_WIDTH, width);
      write_reg(rpnm_pkg::REG_PALETTE_COUNT, count);
      for (int k = 0; k < per_phase; k++) begin
        // stop mid-row now and then until the block has emptied
        if ($urandom_range(0, 39) == 0) drain_results();
        if ($urandom_range(0, 6) == 0) begin
          if ($urandom_range(0, 3) == 0)
            send_entry(IDX_W'($urandom()), palette_copy[$urandom_range(0, DEPTH - 1)]);
          else
            send_entry(IDX_W'($urandom()), COLOUR_W'($urandom()));
        end else begin
          send_word($urandom());
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_empty_palette_after_reset();
    load_full_palette();
    test_channel_order_and_ties();
    test_row_tails();
    test_palette_count_limits();
    test_row_width_limits();
    test_random_traffic(8, 85);
    idle_en = 1'b0;
    test_random_traffic(2, 105);
    drain_results();
    repeat (2 * DEPTH + 16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("rgb24_palette_nearest_match_tb: PASS");
    end else begin
      $display("rgb24_palette_nearest_match_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT);
    $display("rgb24_palette_nearest_match_tb: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rpnm_pkg.sv
rtl/rpnm_ram.sv
rtl/rpnm_sad.sv
rtl/rpnm_search.sv
rtl/rgb24_palette_nearest_match.sv
rtl/rpnm_checker.sv
sim/rgb24_palette_nearest_match_tb.sv
